@@ rtl/rlbt_pkg.sv @@
// Shared constants and controller/datapath interface types for the line bitmap tracker.
package rlbt_pkg;

	// Number of tracked lines and the bitmap geometry that follows from it
	localparam int unsigned LINES  = 1024;
	localparam int unsigned WORDS  = (LINES + 7) / 8;
	localparam int unsigned AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned CNT_W  = AW + 1;
	localparam int unsigned LINE_W = 16;
	localparam int unsigned NEXT_W = 11;
	localparam int unsigned POS_W  = AW + 3;
	localparam int unsigned CMP_W  = LINE_W + 1;

	localparam logic [CMP_W-1:0] LINES_V = CMP_W'(LINES);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;      // latch an accepted request
		logic update;    // test and mark the addressed line
		logic scan_clr;  // restart the scan counter
		logic scan;      // walk the bitmap words
		logic out_load;  // move the result into the output register
	} rlbt_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic hit;       // scan has found the first unmarked line or run out
	} rlbt_sts_t;

endpackage

@@ rtl/received_line_bitmap_tracker.sv @@
// Top level of the received line bitmap tracker.
//
// Request channel (req_valid/req_stall): func and line_number. func 1 marks
// the line as received, func 0 only queries it. A line at or above LINES
// reads as unmarked and is never marked.
// Result channel (res_valid/res_stall): was_marked tells whether the line
// was marked before the request; next_needed is the lowest unmarked line
// after the request, or LINES when every line is marked.
// One request is in flight at a time. The scan reads the bitmap words up
// to and including the first one that is not full, 1 to WORDS words (WORDS
// is 128 at LINES = 1024), one word a cycle through the bitmap RAM's single
// read port. The next request can be accepted as early as the cycle in
// which res_valid rises.
// Reset clears the bitmap at once through per-word valid bits; no clearing
// pass runs. A finished result sits in the output register while the next
// request is accepted; if the receiver still stalls when the next scan ends,
// the block holds that result and keeps req_stall high until it is taken.
module received_line_bitmap_tracker import rlbt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              func,
	input  logic [LINE_W-1:0] line_number,
	output logic              res_valid,
	input  logic              res_stall,
	output logic              was_marked,
	output logic [NEXT_W-1:0] next_needed
);

	rlbt_cmd_t cmd;
	rlbt_sts_t sts;

	rlbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	rlbt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.line_number (line_number),
		.was_marked  (was_marked),
		.next_needed (next_needed)
	);

endmodule

@@ rtl/rlbt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rlbt_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 128,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/rlbt_dp.sv @@
// Datapath: bitmap RAM, per-word valid bits, line test and mark, first-zero scan.
module rlbt_dp import rlbt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rlbt_cmd_t         cmd,
	output rlbt_sts_t         sts,
	input  logic              func,
	input  logic [LINE_W-1:0] line_number,
	output logic              was_marked,
	output logic [NEXT_W-1:0] next_needed
);

	logic              func_q;
	logic [LINE_W-1:0] line_q;
	logic              inrange_q;
	logic              was_q;
	logic [NEXT_W-1:0] next_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_s1;
	logic [AW-1:0]     addr_s1;
	logic              vld_s1;
	logic [WORDS-1:0]  valid_q;
	logic              res_was_q;
	logic [NEXT_W-1:0] res_next_q;

	logic [AW-1:0]     line_word;
	logic [2:0]        bit_sel;
	logic [7:0]        bit_mask;
	logic [AW-1:0]     rd_addr;
	logic              issue;
	logic [7:0]        rd_data;
	logic [7:0]        eff;
	logic              we;
	logic              full;
	logic [2:0]        zero_bit;
	logic [POS_W-1:0]  pos;
	logic [CMP_W-1:0]  pos_w;
	logic [CMP_W-1:0]  cand;
	logic [CMP_W-1:0]  result;
	logic              last;

	// Address decode of the latched line
	assign line_word = line_q[3 +: AW];
	assign bit_sel   = line_q[2:0];
	assign bit_mask  = 8'(1) << bit_sel;

	// Read address: scan counter while scanning, otherwise the request's word
	assign issue   = cmd.scan && (cnt_q < CNT_W'(WORDS));
	assign rd_addr = cmd.scan ? cnt_q[AW-1:0] : line_word;

	// A word never written reads as all zeros
	assign eff = vld_s1 ? rd_data : 8'h00;
	assign we  = cmd.update && func_q && inrange_q;

	rlbt_ram #(
		.WIDTH (8),
		.DEPTH (WORDS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (line_word),
		.wdata (eff | bit_mask),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Latch the accepted request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= func;
			line_q    <= line_number;
			inrange_q <= ({1'b0, line_number} < LINES_V);
		end
	end

	// Track written words; reset marks the whole bitmap empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[line_word] <= 1'b1;
		end
	end

	// Carry the valid bit and address alongside the RAM read
	always_ff @(posedge clk) begin
		vld_s1  <= valid_q[rd_addr];
		addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue;
		end
	end

	// Scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.scan_clr) begin
			cnt_q <= '0;
		end else if (issue) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Find the lowest zero bit of the word under test
	always_comb begin
		zero_bit = 3'd0;
		for (int b = 7; b >= 0; b--) begin
			if (!eff[b]) begin
				zero_bit = 3'(b);
			end
		end
	end

	// Turn the hit into a line number, clipped to LINES past the last line
	assign full    = &eff;
	assign last    = (addr_s1 == AW'(WORDS - 1));
	assign pos     = {addr_s1, zero_bit};
	assign pos_w   = CMP_W'(pos);
	assign cand    = (pos_w < LINES_V) ? pos_w : LINES_V;
	assign result  = full ? LINES_V : cand;
	assign sts.hit = pend_s1 && (!full || last);

	// Test the line, then hold the scan result
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			was_q <= inrange_q && ((eff & bit_mask) != 8'h00);
		end
		if (cmd.scan && sts.hit) begin
			next_q <= result[NEXT_W-1:0];
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_was_q  <= was_q;
			res_next_q <= next_q;
		end
	end

	assign was_marked  = res_was_q;
	assign next_needed = res_next_q;

endmodule

@@ rtl/rlbt_ctrl.sv @@
// Controller: sequences read, update and scan, and owns both handshakes.
module rlbt_ctrl import rlbt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      res_valid,
	input  logic      res_stall,
	output rlbt_cmd_t cmd,
	input  rlbt_sts_t sts
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_UPDATE = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       res_valid_q;
	logic       accept;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	// Decode commands
	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.update   = (state_q == ST_UPDATE);
		cmd.scan_clr = (state_q == ST_UPDATE);
		cmd.scan     = (state_q == ST_SCAN);
		cmd.out_load = (state_q == ST_FINISH) && (!res_valid_q || !res_stall);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_READ;
				end
			end
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_SCAN;
			ST_SCAN: begin
				if (sts.hit) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (cmd.out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= cmd.out_load || (res_valid_q && res_stall);
		end
	end

	assign res_valid = res_valid_q;

endmodule

@@ rtl/rlbt_chk.sv @@
// Port-level checker for the line bitmap tracker and its bind to the top level.
module rlbt_chk import rlbt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              res_valid,
	input logic              res_stall,
	input logic              was_marked,
	input logic [NEXT_W-1:0] next_needed
);

	// A stalled result stays valid
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// A stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(was_marked) && $stable(next_needed))
		else $error("result payload changed while stalled");

	// Accepting a request makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request accepted back to back");

	// No result appears in the cycle after a request is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> !$rose(res_valid))
		else $error("result appeared too early");

endmodule

bind received_line_bitmap_tracker rlbt_chk u_chk (.*);

@@ verif/received_line_bitmap_tracker_checker.sv @@
// Checker that tracks received lines, predicts each answer and compares it with the block.
module received_line_bitmap_tracker_checker import rlbt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  logic              func,
	input  logic [LINE_W-1:0] line_number,
	input  logic              res_valid,
	input  logic              res_stall,
	input  logic              was_marked,
	input  logic [NEXT_W-1:0] next_needed,
	output int                errors,
	output int                outstanding
);

	typedef struct packed {
		logic              was_marked;
		logic [NEXT_W-1:0] next_needed;
	} line_answer_t;

	bit [LINES-1:0] received_lines;
	line_answer_t   pending_answers[$];

	initial begin
		errors      = 0;
		outstanding = 0;
	end

	// Scan from line 0 for the first line not yet received
	function automatic int unsigned lowest_unmarked_line();
		for (int unsigned i = 0; i < LINES; i++) begin
			if (!received_lines[i])
				return i;
		end
		return LINES;
	endfunction

	// Test the line, mark it if asked and in range, then find the next missing line
	function automatic line_answer_t apply_request(logic mark, logic [LINE_W-1:0] line);
		line_answer_t answer;
		answer.was_marked = (line < LINES) ? received_lines[line] : 1'b0;
		if (mark && line < LINES)
			received_lines[line] = 1'b1;
		answer.next_needed = NEXT_W'(lowest_unmarked_line());
		return answer;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		line_answer_t want;
		if (!arst_n) begin
			received_lines = '0;
			pending_answers.delete();
		end else begin
			// compare a taken result with the oldest waiting answer
			if (res_valid && !res_stall) begin
				if (pending_answers.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got was_marked %0d next_needed %0d",
						$time, was_marked, next_needed);
				end else begin
					want = pending_answers.pop_front();
					if (was_marked !== want.was_marked) begin
						errors++;
						$display("%0t: was_marked expected %0d, got %0d",
							$time, want.was_marked, was_marked);
					end
					if (next_needed !== want.next_needed) begin
						errors++;
						$display("%0t: next_needed expected %0d, got %0d",
							$time, want.next_needed, next_needed);
					end
				end
			end
			// predict the answer of an accepted request
			if (req_valid && !req_stall)
				pending_answers.push_back(apply_request(func, line_number));
		end
		outstanding = pending_answers.size();
	end

endmodule

@@ verif/received_line_bitmap_tracker_tb.sv @@
// Testbench top: clock, reset, request and result traffic and the verdict for the tracker.
module received_line_bitmap_tracker_tb;
	import rlbt_pkg::*;

	localparam logic OP_QUERY     = 1'b0;
	localparam logic OP_MARK      = 1'b1;
	localparam int   RANDOM_ITEMS = 1600;
	localparam int   PHASE_ITEMS  = 300;
	localparam int   HOLD_AT      = 1205;
	localparam int   HOLD_CYCLES  = 400;
	localparam int   DRAIN_CYCLES = 140;
	localparam int   BLOCK_LINES  = 32;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic              func;
	logic [LINE_W-1:0] line_number;
	logic              res_valid;
	logic              res_stall;
	logic              was_marked;
	logic [NEXT_W-1:0] next_needed;

	int errors;
	int outstanding;
	int idle_pct  = 0;
	int stall_pct = 0;
	bit hold_off  = 1'b0;

	received_line_bitmap_tracker dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.func        (func),
		.line_number (line_number),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.was_marked  (was_marked),
		.next_needed (next_needed)
	);

	received_line_bitmap_tracker_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.func        (func),
		.line_number (line_number),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.was_marked  (was_marked),
		.next_needed (next_needed),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Stall results at random, or hold off for a long stretch when asked
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
				hold_off = 1'b0;
			end else begin
				res_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offer one request after a random gap and hold it until accepted
	task automatic send_req(input logic op, input logic [LINE_W-1:0] line);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid   <= 1'b1;
		func        <= op;
		line_number <= line;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Drop valid and wait until every answer has come back
	task automatic drain_answers();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned fill_order[LINES];
		int unsigned swap_tmp;
		int          fill_pos;
		int          sent;
		int          roll;
		int          j;

		arst_n      = 1'b0;
		req_valid   = 1'b0;
		func        = OP_QUERY;
		line_number = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty bitmap, repeats, range ends, out of range, first word filling up
		send_req(OP_QUERY, LINE_W'(0));
		send_req(OP_MARK,  LINE_W'(0));
		send_req(OP_MARK,  LINE_W'(0));
		send_req(OP_QUERY, LINE_W'(0));
		send_req(OP_QUERY, LINE_W'(1));
		send_req(OP_MARK,  LINE_W'(1));
		send_req(OP_MARK,  LINE_W'(LINES - 1));
		send_req(OP_QUERY, LINE_W'(LINES - 1));
		send_req(OP_MARK,  LINE_W'(LINES));
		send_req(OP_QUERY, LINE_W'(LINES));
		send_req(OP_MARK,  LINE_W'(16'hFFFF));
		send_req(OP_QUERY, LINE_W'(16'hFFFF));
		send_req(OP_MARK,  LINE_W'(16'h8000));
		send_req(OP_QUERY, LINE_W'(16'h7FFF));
		send_req(OP_MARK,  LINE_W'(16'h5555));
		send_req(OP_MARK,  LINE_W'(16'h02AA));
		send_req(OP_QUERY, LINE_W'(16'h02AA));
		send_req(OP_MARK,  LINE_W'(16'h0155));
		for (int n = 2; n < 8; n++)
			send_req(OP_MARK, LINE_W'(n));
		send_req(OP_QUERY, LINE_W'(8));

		// build a mostly rising fill order, shuffled inside each block of lines
		for (int unsigned i = 0; i < LINES; i++)
			fill_order[i] = i;
		for (int b = 0; b < LINES; b += BLOCK_LINES) begin
			for (int i = BLOCK_LINES - 1; i > 0; i--) begin
				j = $urandom_range(i);
				if (b + i < LINES && b + j < LINES) begin
					swap_tmp          = fill_order[b + i];
					fill_order[b + i] = fill_order[b + j];
					fill_order[b + j] = swap_tmp;
				end
			end
		end

		// random: fill the bitmap step by step, mixed with queries and stray lines
		fill_pos = 0;
		sent     = 0;
		while (fill_pos < LINES || sent < RANDOM_ITEMS) begin
			if (sent % PHASE_ITEMS == 0) begin
				drain_answers();
				case ((sent / PHASE_ITEMS) % 4)
					0: begin idle_pct = 0;  stall_pct = 0;  end
					1: begin idle_pct = 53; stall_pct = 0;  end
					2: begin idle_pct = 0;  stall_pct = 53; end
					default: begin idle_pct = 18; stall_pct = 18; end
				endcase
			end
			if (sent == HOLD_AT)
				hold_off = 1'b1;
			roll = $urandom_range(99);
			if (roll < 60 && fill_pos < LINES) begin
				send_req(OP_MARK, LINE_W'(fill_order[fill_pos]));
				fill_pos++;
			end else if (roll < 80) begin
				send_req(OP_QUERY, LINE_W'($urandom_range(LINES - 1)));
			end else if (roll < 90) begin
				send_req(OP_MARK, LINE_W'($urandom_range(LINES - 1)));
			end else begin
				send_req(1'($urandom_range(1)), LINE_W'($urandom_range(16'hFFFF, LINES)));
			end
			sent++;
		end

		drain_answers();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("received_line_bitmap_tracker: match");
		else
			$display("received_line_bitmap_tracker: mismatch");
		$finish;
	end

	// Stop a hung run
	initial begin
		#20_000_000;
		$display("received_line_bitmap_tracker: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
rtl/rlbt_pkg.sv
rtl/rlbt_ram.sv
rtl/rlbt_dp.sv
rtl/rlbt_ctrl.sv
rtl/received_line_bitmap_tracker.sv
rtl/rlbt_chk.sv
verif/received_line_bitmap_tracker_checker.sv
verif/received_line_bitmap_tracker_tb.sv
